/* hdl/lcd_window_write_sequencer_macros.svh */
// Assertion macros for the display window write sequencer.
// Included by the top level; no other dependencies.
`ifndef LCD_WINDOW_WRITE_SEQUENCER_MACROS_SVH
`define LCD_WINDOW_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define LCDWS_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define LCDWS_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lcdws_pkg.sv */
// Shared types and constants of the display window write sequencer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lcdws_pkg;

	localparam int unsigned MAX_SIDE_DEFAULT    = 320;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [7:0]  OP_COLS = 8'h2A;
	localparam logic [7:0]  OP_ROWS = 8'h2B;
	localparam logic [7:0]  OP_MEMW = 8'h2C;
	localparam logic [16:0] CNT_MAX = 17'h1FFFF;

	localparam logic [8:0]  WIDTH_RESET  = 9'd240;
	localparam logic [8:0]  HEIGHT_RESET = 9'd320;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_FILL = 2'd1,
		CMD_DRAW = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_COL_OFF = 2'd2,
		REG_ROW_OFF = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		JOB_DRAW  = 2'd0,
		JOB_FILL  = 2'd1,
		JOB_PIXEL = 2'd2
	} job_kind_t;

	typedef enum logic [3:0] {
		ST_COL_CMD  = 4'd0,
		ST_COL_S_HI = 4'd1,
		ST_COL_S_LO = 4'd2,
		ST_COL_E_HI = 4'd3,
		ST_COL_E_LO = 4'd4,
		ST_ROW_CMD  = 4'd5,
		ST_ROW_S_HI = 4'd6,
		ST_ROW_S_LO = 4'd7,
		ST_ROW_E_HI = 4'd8,
		ST_ROW_E_LO = 4'd9,
		ST_MEMW     = 4'd10,
		ST_PIX_HI   = 4'd11,
		ST_PIX_LO   = 4'd12
	} step_t;

	// One unit of work for the byte sequencer.
	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] col_start;
		logic [15:0] col_end;
		logic [15:0] row_start;
		logic [15:0] row_end;
		logic [15:0] color;
		logic        cs_rel;
	} job_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_data;
		logic       cs_rel;
		logic       last;
	} byte_t;

endpackage

`default_nettype wire

/* hdl/lcd_window_write_sequencer.sv */
// Top level of the display window write sequencer: register port, front end,
// job queue and byte sequencer. Depends on lcdws_pkg and the assertion macros.
//
//   Channel   Handshake            Payload
//   input     push / full          command, x_coord, y_coord, pixel_color
//   result    empty / pop          out_byte, is_data, select_release, last
//   config    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// A command is classified in the cycle of its transfer; a loaded job passes from
// the job and step registers to the output register, and bytes leave at one per
// cycle while popped. A draw sends 13 bytes, a fill header 11, a tick pixel 2;
// the byte sequencer sets the pace. Rejected commands are taken but produce nothing.
// Reset clears the fill counter, the queue and the sequencer; no clearing pass.
// full rises only when the job queue is full, which a stalled result can cause.
`default_nettype none

`include "lcd_window_write_sequencer_macros.svh"

module lcd_window_write_sequencer #(
	parameter int unsigned MAX_SIDE    = lcdws_pkg::MAX_SIDE_DEFAULT,
	parameter int unsigned QUEUE_DEPTH = lcdws_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] x_coord,
	input  wire logic [15:0] y_coord,
	input  wire logic [15:0] pixel_color,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             is_data,
	output logic             select_release,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [8:0]           width_q;
	logic [8:0]           height_q;
	logic [15:0]          col_off_q;
	logic [15:0]          row_off_q;
	lcdws_pkg::reg_idx_t  reg_idx;
	logic                 cfg_write;
	logic                 accept;
	logic                 job_push;
	lcdws_pkg::job_t      job;
	logic                 fill_pending;
	logic                 q_empty;
	logic                 q_pop;
	lcdws_pkg::job_t      q_data;
	lcdws_pkg::byte_t     result;

	assign pready    = 1'b1;
	assign reg_idx   = lcdws_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= lcdws_pkg::WIDTH_RESET;
			height_q  <= lcdws_pkg::HEIGHT_RESET;
			col_off_q <= '0;
			row_off_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				lcdws_pkg::REG_WIDTH:   width_q   <= pwdata[8:0];
				lcdws_pkg::REG_HEIGHT:  height_q  <= pwdata[8:0];
				lcdws_pkg::REG_COL_OFF: col_off_q <= pwdata[15:0];
				lcdws_pkg::REG_ROW_OFF: row_off_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lcdws_pkg::REG_WIDTH:   prdata = {23'd0, width_q};
			lcdws_pkg::REG_HEIGHT:  prdata = {23'd0, height_q};
			lcdws_pkg::REG_COL_OFF: prdata = {16'd0, col_off_q};
			lcdws_pkg::REG_ROW_OFF: prdata = {16'd0, row_off_q};
			default:                prdata = '0;
		endcase
	end

	assign accept = push && !full;

	lcdws_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.command       (command),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.pixel_color   (pixel_color),
		.panel_width   (width_q),
		.panel_height  (height_q),
		.column_offset (col_off_q),
		.row_offset    (row_off_q),
		.job_push      (job_push),
		.job           (job),
		.fill_pending  (fill_pending)
	);

	lcdws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job),
		.full      (full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	lcdws_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	assign out_byte       = result.data;
	assign is_data        = result.is_data;
	assign select_release = result.cs_rel;
	assign last           = result.last;

	// Every command byte ends with chip select raised.
	`LCDWS_ASSERT_NOW(a_cmd_releases, clk, arst_n, !empty && !is_data, select_release, "command byte without chip select release")
	// The only command byte that can close a transfer group is the memory write.
	`LCDWS_ASSERT_NOW(a_last_cmd_memw, clk, arst_n, !empty && last && !is_data, out_byte == lcdws_pkg::OP_MEMW, "last command byte is not memory write")
	// A fill command that arrives during a pending fill leaves the fill pending.
	`LCDWS_ASSERT_NEXT(a_fill_ignored, clk, arst_n, accept && fill_pending && (command == lcdws_pkg::CMD_FILL), fill_pending, "pending fill lost on ignored fill command")

endmodule

`default_nettype wire

/* hdl/lcdws_front.sv */
// Front end: takes commands, checks them against the panel and the fill state,
// and builds jobs for the byte sequencer. Depends on lcdws_pkg.
`default_nettype none

module lcdws_front #(
	parameter int unsigned MAX_SIDE = lcdws_pkg::MAX_SIDE_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [1:0]        command,
	input  wire logic [15:0]       x_coord,
	input  wire logic [15:0]       y_coord,
	input  wire logic [15:0]       pixel_color,
	input  wire logic [8:0]        panel_width,
	input  wire logic [8:0]        panel_height,
	input  wire logic [15:0]       column_offset,
	input  wire logic [15:0]       row_offset,
	output logic                   job_push,
	output lcdws_pkg::job_t        job,
	output logic                   fill_pending
);

	logic [16:0]         remaining_q;
	logic [15:0]         fill_color_q;
	logic [16:0]         remaining_d;
	logic [15:0]         fill_color_d;
	logic [8:0]          w_eff;
	logic [8:0]          h_eff;
	logic [15:0]         w16;
	logic [15:0]         h16;
	logic [17:0]         area;
	logic [16:0]         area_sat;
	logic                job_valid;
	lcdws_pkg::cmd_t     cmd;

	assign fill_pending = (remaining_q != 17'd0);

	always_comb begin
		w_eff    = (32'(panel_width) > MAX_SIDE) ? 9'(MAX_SIDE) : panel_width;
		h_eff    = (32'(panel_height) > MAX_SIDE) ? 9'(MAX_SIDE) : panel_height;
		w16      = {7'd0, w_eff};
		h16      = {7'd0, h_eff};
		area     = 18'(w_eff) * 18'(h_eff);
		area_sat = (area > {1'b0, lcdws_pkg::CNT_MAX}) ? lcdws_pkg::CNT_MAX : area[16:0];
		cmd      = lcdws_pkg::cmd_t'(command);

		job_valid    = 1'b0;
		job          = '0;
		remaining_d  = remaining_q;
		fill_color_d = fill_color_q;

		unique case (cmd)
			lcdws_pkg::CMD_TICK: begin
				if (fill_pending) begin
					job_valid   = 1'b1;
					job.kind    = lcdws_pkg::JOB_PIXEL;
					job.color   = fill_color_q;
					job.cs_rel  = (remaining_q == 17'd1);
					remaining_d = remaining_q - 17'd1;
				end
			end
			lcdws_pkg::CMD_FILL: begin
				if (!fill_pending) begin
					// A zero-sized panel still sends the header; the end address wraps.
					job_valid     = 1'b1;
					job.kind      = lcdws_pkg::JOB_FILL;
					job.col_start = column_offset;
					job.col_end   = w16 - 16'd1 + column_offset;
					job.row_start = row_offset;
					job.row_end   = h16 - 16'd1 + row_offset;
					remaining_d   = area_sat;
					fill_color_d  = pixel_color;
				end
			end
			lcdws_pkg::CMD_DRAW: begin
				if (!fill_pending && (x_coord < w16) && (y_coord < h16)) begin
					job_valid     = 1'b1;
					job.kind      = lcdws_pkg::JOB_DRAW;
					job.col_start = x_coord + column_offset;
					job.col_end   = x_coord + column_offset;
					job.row_start = y_coord + row_offset;
					job.row_end   = y_coord + row_offset;
					job.color     = pixel_color;
					job.cs_rel    = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign job_push = accept && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q  <= '0;
			fill_color_q <= '0;
		end else if (accept) begin
			remaining_q  <= remaining_d;
			fill_color_q <= fill_color_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/lcdws_queue.sv */
// Short register queue of jobs between the front end and the byte sequencer.
// Depends on lcdws_pkg for the job type.
`default_nettype none

module lcdws_queue #(
	parameter int unsigned DEPTH = lcdws_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lcdws_pkg::job_t   push_data,
	output logic                   full,
	input  wire logic              pop,
	output lcdws_pkg::job_t        pop_data,
	output logic                   empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	lcdws_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/lcdws_back.sv */
// Byte sequencer: walks one job at a time through its bytes and holds the
// waiting result in an output register. Depends on lcdws_pkg.
`default_nettype none

module lcdws_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire lcdws_pkg::job_t   q_data,
	output logic                   q_pop,
	output logic                   empty,
	input  wire logic              pop,
	output lcdws_pkg::byte_t       result
);

	logic                busy_q;
	lcdws_pkg::job_t     cur_q;
	lcdws_pkg::step_t    step_q;
	logic                out_valid_q;
	lcdws_pkg::byte_t    out_q;
	lcdws_pkg::byte_t    nxt;
	logic                advance;
	logic                at_last;
	logic                load;

	assign advance = busy_q && (!out_valid_q || pop);
	assign at_last = (cur_q.kind == lcdws_pkg::JOB_FILL) ? (step_q == lcdws_pkg::ST_MEMW)
							     : (step_q == lcdws_pkg::ST_PIX_LO);
	// The next job is taken in the same cycle the last byte of the current one is written to the output register.
	assign load    = !q_empty && (!busy_q || (advance && at_last));
	assign q_pop   = load;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_comb begin
		nxt      = '0;
		nxt.last = at_last;
		unique case (step_q)
			lcdws_pkg::ST_COL_CMD: begin
				nxt.data   = lcdws_pkg::OP_COLS;
				nxt.cs_rel = 1'b1;
			end
			lcdws_pkg::ST_COL_S_HI: begin
				nxt.data    = cur_q.col_start[15:8];
				nxt.is_data = 1'b1;
			end
			lcdws_pkg::ST_COL_S_LO: begin
				nxt.data    = cur_q.col_start[7:0];
				nxt.is_data = 1'b1;
			end
			lcdws_pkg::ST_COL_E_HI: begin
				nxt.data    = cur_q.col_end[15:8];
				nxt.is_data = 1'b1;
			end
			lcdws_pkg::ST_COL_E_LO: begin
				nxt.data    = cur_q.col_end[7:0];
				nxt.is_data = 1'b1;
				nxt.cs_rel  = 1'b1;
			end
			lcdws_pkg::ST_ROW_CMD: begin
				nxt.data   = lcdws_pkg::OP_ROWS;
				nxt.cs_rel = 1'b1;
			end
			lcdws_pkg::ST_ROW_S_HI: begin
				nxt.data    = cur_q.row_start[15:8];
				nxt.is_data = 1'b1;
			end
			lcdws_pkg::ST_ROW_S_LO: begin
				nxt.data    = cur_q.row_start[7:0];
				nxt.is_data = 1'b1;
			end
			lcdws_pkg::ST_ROW_E_HI: begin
				nxt.data    = cur_q.row_end[15:8];
				nxt.is_data = 1'b1;
			end
			lcdws_pkg::ST_ROW_E_LO: begin
				nxt.data    = cur_q.row_end[7:0];
				nxt.is_data = 1'b1;
				nxt.cs_rel  = 1'b1;
			end
			lcdws_pkg::ST_MEMW: begin
				nxt.data   = lcdws_pkg::OP_MEMW;
				nxt.cs_rel = 1'b1;
			end
			lcdws_pkg::ST_PIX_HI: begin
				nxt.data    = cur_q.color[15:8];
				nxt.is_data = 1'b1;
			end
			lcdws_pkg::ST_PIX_LO: begin
				nxt.data    = cur_q.color[7:0];
				nxt.is_data = 1'b1;
				nxt.cs_rel  = cur_q.cs_rel;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= lcdws_pkg::ST_COL_CMD;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				step_q <= (q_data.kind == lcdws_pkg::JOB_PIXEL) ? lcdws_pkg::ST_PIX_HI
									       : lcdws_pkg::ST_COL_CMD;
			end else if (advance && at_last) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				step_q <= lcdws_pkg::step_t'(step_q + 4'd1);
			end

			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
		if (advance) begin
			out_q <= nxt;
		end
	end

endmodule

`default_nettype wire
